// File: hdl/smfs_pkg.sv
// package for the spacecraft mode and fault supervisor
// transaction types, opcode, mode, ack and register index codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package smfs_pkg;

  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_PING        = 3'd1;
  localparam logic [2:0] OP_STATUS      = 3'd2;
  localparam logic [2:0] OP_RESET       = 3'd3;
  localparam logic [2:0] OP_SET_MODE    = 3'd4;
  localparam logic [2:0] OP_RESET_FAULT = 3'd5;
  localparam logic [2:0] OP_INJECT      = 3'd6;
  localparam logic [2:0] OP_CLEAR       = 3'd7;

  localparam logic [1:0] MODE_BOOT   = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_SAFE   = 2'd2;
  localparam logic [1:0] MODE_FAULT  = 2'd3;

  localparam logic [1:0] ACK_OK       = 2'd0;
  localparam logic [1:0] ACK_INVALID  = 2'd1;
  localparam logic [1:0] ACK_REJECTED = 2'd2;

  localparam logic CFG_INIT_BATTERY = 1'b0;
  localparam logic CFG_INIT_TEMP    = 1'b1;

  localparam logic [6:0]        BATTERY_FULL = 7'd100;
  localparam logic signed [7:0] TEMP_RESET   = 8'sd22;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] delta_ms;
    logic        mode_present;
    logic [1:0]  mode_req;
    logic        fault_present;
    logic [3:0]  fault_code;
  } smfs_in_t;

  typedef struct packed {
    logic              is_telemetry;
    logic [2:0]        command_echo;
    logic [1:0]        ack_status;
    logic [31:0]       timestamp_out;
    logic [31:0]       sequence_out;
    logic [1:0]        mode_out;
    logic [6:0]        battery_out;
    logic signed [7:0] temperature_out;
    logic [7:0]        fault_flags_out;
    logic [31:0]       uptime_out;
  } smfs_out_t;

endpackage

`default_nettype wire

// File: hdl/smfs_modred.sv
// input pipeline: registers transactions and reduces delta_ms modulo the drain period
// reciprocal multiply, back multiply and one correction; depends on smfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module smfs_modred
  import smfs_pkg::*;
#(
  parameter int unsigned DRAIN_PERIOD_MS = 1000,
  parameter int unsigned RES_W           = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire smfs_in_t         in_data,
  output logic                  st_valid,
  output smfs_in_t              st_data,
  output logic [RES_W-1:0]      el_mod
);

  localparam logic [32:0]      RECIP = 33'((64'd1 << 32) / DRAIN_PERIOD_MS);
  localparam logic [RES_W:0]   PW    = (RES_W + 1)'(DRAIN_PERIOD_MS);
  localparam logic [31+RES_W:0] PQ   = (32 + RES_W)'(DRAIN_PERIOD_MS);

  logic                v1_r, v2_r, v3_r;
  smfs_in_t            d1_r, d2_r, d3_r;
  logic [31:0]         q2_r, q2_nxt;
  logic [RES_W:0]      r3_r, r3_nxt;
  logic [64:0]         prod1;
  logic [31+RES_W:0]   qp;
  logic [31:0]         r_full;
  logic [RES_W:0]      r_fix;

  // quotient estimate, at most one short of the true quotient
  assign prod1  = {33'd0, d1_r.delta_ms} * {32'd0, RECIP};
  assign q2_nxt = prod1[63:32];

  assign qp     = (32 + RES_W)'(q2_r) * PQ;
  assign r_full = d2_r.delta_ms - qp[31:0];
  assign r3_nxt = r_full[RES_W:0];

  assign r_fix  = (r3_r >= PW) ? (r3_r - PW) : r3_r;
  assign el_mod = r_fix[RES_W-1:0];

  assign st_valid = v3_r;
  assign st_data  = d3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r <= in_data;
      d2_r <= d1_r;
      q2_r <= q2_nxt;
      d3_r <= d2_r;
      r3_r <= r3_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/smfs_core.sv
// supervisor state, configuration registers and result register
// one transaction updates the state per cycle unless a waiting result is stalled; depends on smfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module smfs_core
  import smfs_pkg::*;
#(
  parameter int unsigned DRAIN_PERIOD_MS = 1000,
  parameter int unsigned FAULT_BITS      = 8,
  parameter int unsigned RES_W           = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wen,
  input  wire logic             cfg_index,
  input  wire logic [7:0]       cfg_wdata,
  input  wire logic             st_valid,
  input  wire smfs_in_t         st_data,
  input  wire logic [RES_W-1:0] el_mod,
  input  wire logic             out_stall,
  output logic                  adv,
  output logic                  out_valid,
  output smfs_out_t             out_data
);

  localparam logic [RES_W:0] PW       = (RES_W + 1)'(DRAIN_PERIOD_MS);
  localparam logic [RES_W:0] WRAP_RES = (RES_W + 1)'((64'd1 << 32) % DRAIN_PERIOD_MS);

  logic [6:0]            init_batt_r;
  logic signed [7:0]     init_temp_r;
  logic [1:0]            mode_r, mode_nxt;
  logic                  boot_r, boot_nxt;
  logic [FAULT_BITS-1:0] flags_r, flags_nxt;
  logic [31:0]           ts_r, ts_nxt;
  logic [31:0]           up_r, up_nxt;
  logic [31:0]           seq_r, seq_nxt;
  logic [6:0]            batt_r, batt_nxt;
  logic signed [7:0]     temp_r, temp_nxt;
  logic [RES_W-1:0]      res_r, res_nxt;
  logic                  out_valid_r;
  smfs_out_t             out_r, out_nxt;

  logic [RES_W:0]        res_sum;
  logic [RES_W:0]        res_fix;
  logic [32:0]           up_sum;
  logic [RES_W:0]        res_wrap;
  logic [3:0]            code_m1;
  logic                  code_ok;
  logic [FAULT_BITS-1:0] fbit;
  logic [1:0]            ack;
  logic [1:0]            shown;
  logic [FAULT_BITS+7:0] flags_ext;

  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign res_sum = {1'b0, res_r} + {1'b0, el_mod};
  assign res_fix = (res_sum >= PW) ? (res_sum - PW) : res_sum;

  // uptime wrap drops 2^32, which shifts the residue back by 2^32 mod the period
  assign up_sum   = {1'b0, up_r} + {1'b0, st_data.delta_ms};
  assign res_wrap = !up_sum[32]          ? res_fix :
                    (res_fix >= WRAP_RES) ? (res_fix - WRAP_RES) :
                                            (res_fix + PW - WRAP_RES);

  assign code_m1 = st_data.fault_code - 4'd1;
  assign code_ok = st_data.fault_present && (st_data.fault_code != 4'd0)
                   && (32'(st_data.fault_code) <= 32'(FAULT_BITS));

  always_comb begin
    for (int i = 0; i < FAULT_BITS; i++) begin
      fbit[i] = (32'(code_m1) == 32'(i));
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    boot_nxt  = boot_r;
    flags_nxt = flags_r;
    ts_nxt    = ts_r;
    up_nxt    = up_r;
    seq_nxt   = seq_r;
    batt_nxt  = batt_r;
    temp_nxt  = temp_r;
    res_nxt   = res_r;
    ack       = ACK_OK;
    shown     = mode_r;

    unique case (st_data.opcode)
      OP_TICK: begin
        ts_nxt  = ts_r + st_data.delta_ms;
        up_nxt  = up_sum[31:0];
        seq_nxt = seq_r + 32'd1;
        res_nxt = res_wrap[RES_W-1:0];
        if (boot_r) begin
          if ((up_nxt != 32'd0) && (res_wrap == '0) && (batt_r != 7'd0)) begin
            batt_nxt = batt_r - 7'd1;
          end
          if ((flags_r != '0) && (mode_r == MODE_NORMAL)) begin
            mode_nxt = MODE_SAFE;
          end
        end
        shown = mode_nxt;
        if (!boot_r) begin
          boot_nxt = 1'b1;
          mode_nxt = MODE_NORMAL;
        end
      end
      OP_PING, OP_STATUS: begin
      end
      OP_RESET: begin
        mode_nxt  = MODE_BOOT;
        boot_nxt  = 1'b0;
        flags_nxt = '0;
        ts_nxt    = 32'd0;
        up_nxt    = 32'd0;
        seq_nxt   = 32'd0;
        res_nxt   = '0;
        batt_nxt  = (init_batt_r > BATTERY_FULL) ? BATTERY_FULL : init_batt_r;
        temp_nxt  = init_temp_r;
      end
      OP_SET_MODE: begin
        if (!st_data.mode_present) begin
          ack = ACK_INVALID;
        end else if ((flags_r != '0) && (st_data.mode_req == MODE_NORMAL)) begin
          ack = ACK_REJECTED;
        end else begin
          mode_nxt = st_data.mode_req;
        end
      end
      OP_RESET_FAULT: begin
        flags_nxt = '0;
        if ((mode_r == MODE_SAFE) || (mode_r == MODE_FAULT)) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      OP_INJECT: begin
        if (!code_ok) begin
          ack = ACK_INVALID;
        end else begin
          flags_nxt = flags_r | fbit;
          if (mode_r == MODE_NORMAL) begin
            mode_nxt = MODE_SAFE;
          end
        end
      end
      OP_CLEAR: begin
        if (!code_ok) begin
          ack = ACK_INVALID;
        end else begin
          flags_nxt = flags_r & ~fbit;
          if ((flags_nxt == '0) && (mode_r == MODE_SAFE)) begin
            mode_nxt = MODE_NORMAL;
          end
        end
      end
      default: begin
      end
    endcase

    if (st_data.opcode != OP_TICK) begin
      shown = mode_nxt;
    end
  end

  assign flags_ext = {8'd0, flags_nxt};

  always_comb begin
    out_nxt.is_telemetry    = (st_data.opcode == OP_TICK);
    out_nxt.command_echo    = st_data.opcode;
    out_nxt.ack_status      = ack;
    out_nxt.timestamp_out   = ts_nxt;
    out_nxt.sequence_out    = seq_nxt;
    out_nxt.mode_out        = shown;
    out_nxt.battery_out     = batt_nxt;
    out_nxt.temperature_out = temp_nxt;
    out_nxt.fault_flags_out = flags_ext[7:0];
    out_nxt.uptime_out      = up_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_batt_r <= BATTERY_FULL;
      init_temp_r <= TEMP_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_INIT_BATTERY: init_batt_r <= cfg_wdata[6:0];
        CFG_INIT_TEMP:    init_temp_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_BOOT;
      boot_r      <= 1'b0;
      flags_r     <= '0;
      ts_r        <= 32'd0;
      up_r        <= 32'd0;
      seq_r       <= 32'd0;
      batt_r      <= BATTERY_FULL;
      temp_r      <= TEMP_RESET;
      res_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_valid;
      if (st_valid) begin
        mode_r  <= mode_nxt;
        boot_r  <= boot_nxt;
        flags_r <= flags_nxt;
        ts_r    <= ts_nxt;
        up_r    <= up_nxt;
        seq_r   <= seq_nxt;
        batt_r  <= batt_nxt;
        temp_r  <= temp_nxt;
        res_r   <= res_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && st_valid) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/spacecraft_mode_fault_supervisor.sv
// spacecraft mode and fault supervisor, top level
// a result passes the three input stages for the drain-period residue and then the
// result register; the edge that accepts a transaction loads the first input stage
// throughput: one transaction per cycle; the whole pipeline holds only while out_stall
// holds a waiting result; pipeline data and result registers have no reset
// reset: synchronous rst_n clears all other state, registers load 100 and 22, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module spacecraft_mode_fault_supervisor
  import smfs_pkg::*;
#(
  parameter int unsigned DRAIN_PERIOD_MS = 1000,
  parameter int unsigned FAULT_BITS      = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wen,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire smfs_in_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output smfs_out_t       out_data
);

  localparam int unsigned RES_W = $clog2(DRAIN_PERIOD_MS + 1);

  logic             adv;
  logic             st_valid;
  smfs_in_t         st_data;
  logic [RES_W-1:0] el_mod;

  assign in_stall = !adv;

  smfs_modred #(
    .DRAIN_PERIOD_MS (DRAIN_PERIOD_MS),
    .RES_W           (RES_W)
  ) u_modred (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .st_valid (st_valid),
    .st_data  (st_data),
    .el_mod   (el_mod)
  );

  smfs_core #(
    .DRAIN_PERIOD_MS (DRAIN_PERIOD_MS),
    .FAULT_BITS      (FAULT_BITS),
    .RES_W           (RES_W)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .st_valid  (st_valid),
    .st_data   (st_data),
    .el_mod    (el_mod),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: hdl/smfs_checker.sv
// port-level checks for the supervisor top level, with its bind
// depends on smfs_pkg and spacecraft_mode_fault_supervisor
`timescale 1ns / 1ps
`default_nettype none

module smfs_checker
  import smfs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire smfs_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire smfs_out_t out_data
);

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled input changed");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // input is only held back by a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // telemetry answers ticks only and is never refused
  a_tele: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_telemetry == (out_data.command_echo == OP_TICK))
                  && (!out_data.is_telemetry || (out_data.ack_status == ACK_OK)))
    else $error("telemetry flag or ack mismatch");

  // battery stays within percent range
  a_batt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.battery_out <= BATTERY_FULL))
    else $error("battery above full");

endmodule

bind spacecraft_mode_fault_supervisor smfs_checker u_smfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
